// ----- hw/rtl/pim_pkg.sv -----
// Shared constants and types for the PPS interval monitor.
`timescale 1ns / 1ps

package pim_pkg;

    // Timer rate in ticks per second and the microsecond scale.
    localparam int unsigned      TIMER_HZ      = 1000000;
    localparam longint unsigned  US_PER_SECOND = 64'd1000000;
    localparam int               US_W          = $clog2(US_PER_SECOND + 1);
    localparam logic [US_W-1:0]  US_MULT       = US_W'(US_PER_SECOND);

    // Exact division of a 64-bit value by TIMER_HZ as a multiply by a
    // 65-bit reciprocal followed by a right shift of 64 + RECIP_SHIFT.
    // Bit 64 of the reciprocal is always set, so only the low 64 bits are
    // kept and the top bit is applied as an added copy of the dividend.
    localparam int               RECIP_SHIFT   = $clog2(TIMER_HZ);
    localparam logic [127:0]     RECIP_FULL    =
        ((128'd1 << (64 + RECIP_SHIFT)) / 128'(TIMER_HZ)) + 128'd1;
    localparam logic [63:0]      RECIP_LO      = RECIP_FULL[63:0];

    // Configuration register file.
    localparam int               CFG_W         = 32;
    typedef logic [1:0]          t_cfg_idx;
    typedef logic [CFG_W-1:0]    t_cfg_val;

    localparam t_cfg_idx         CFG_MIN_INTERVAL = 2'd0;
    localparam t_cfg_idx         CFG_MAX_INTERVAL = 2'd1;
    localparam t_cfg_idx         CFG_NOM_INTERVAL = 2'd2;

    localparam t_cfg_val         RST_MIN_INTERVAL = 32'd990000;
    localparam t_cfg_val         RST_MAX_INTERVAL = 32'd1010000;
    localparam t_cfg_val         RST_NOM_INTERVAL = 32'd1000000;

endpackage

// ----- hw/rtl/pim_pps_if.sv -----
// Channel carrying one captured timer count per PPS edge.
`timescale 1ns / 1ps

interface pim_pps_if;
    logic        valid;
    logic        ready;
    logic [63:0] capture_count;

    modport source (output valid, output capture_count, input ready);
    modport sink   (input valid, input capture_count, output ready);
endinterface

// ----- hw/rtl/pim_res_if.sv -----
// Channel carrying one interval result per PPS edge.
`timescale 1ns / 1ps

interface pim_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] edge_time_us;
    logic [31:0] period_out;
    logic [31:0] jitter_out;
    logic        first_edge;
    logic        interval_ok;
    logic [31:0] edges_seen;
    logic [31:0] good_intervals;
    logic [31:0] bad_intervals;

    modport source (
        output valid, output edge_time_us, output period_out, output jitter_out,
        output first_edge, output interval_ok, output edges_seen,
        output good_intervals, output bad_intervals, input ready
    );
    modport sink (
        input valid, input edge_time_us, input period_out, input jitter_out,
        input first_edge, input interval_ok, input edges_seen,
        input good_intervals, input bad_intervals, output ready
    );
endinterface

// ----- hw/rtl/pps_interval_monitor.sv -----
// Top level of the PPS period and jitter monitor.
//
// The block takes one timer count per PPS rising edge on the i_pps channel
// and returns one result per edge on the o_res channel, in order. Each
// result holds the edge time in microseconds, the measured period against
// the previous edge, the jitter from the nominal period, first-edge and
// valid-interval flags, and the running edge, good and bad interval counts.
// Limits and the nominal period are written through the i_cfg_* port while
// no edge is in flight; index 0 is the minimum, 1 the maximum, 2 the nominal
// period, and a write to index 3 is dropped.
// The datapath is eight register stages: six of tick-to-microsecond
// conversion (multiply by one million, then an exact reciprocal multiply split
// into 32-bit partial products) and two of interval check. The stage taking an
// i_pps transfer loads at that edge; the result then moves through the later
// stages in order to o_res. One transfer per cycle is sustained on both channels
// while o_res is ready. Every stage holds its data while the receiver stalls
// and empty stages keep filling, so i_pps stays ready until all eight are full.
// Synchronous reset empties the pipeline, clears the stored edge time and the
// counters, and loads the default limits 990000, 1010000 and 1000000 us.
`timescale 1ns / 1ps

module pps_interval_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pim_pps_if.sink             i_pps,
    pim_res_if.source           o_res,
    input  logic                i_cfg_we,
    input  pim_pkg::t_cfg_idx   i_cfg_idx,
    input  pim_pkg::t_cfg_val   i_cfg_data
);

    pim_pkg::t_cfg_val r_min_interval;
    pim_pkg::t_cfg_val r_max_interval;
    pim_pkg::t_cfg_val r_nom_interval;

    logic        conv_rdy;
    logic        time_vld;
    logic        time_rdy;
    logic [63:0] time_us;

    // Configuration register file; unused indexes fall through untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= pim_pkg::RST_MIN_INTERVAL;
            r_max_interval <= pim_pkg::RST_MAX_INTERVAL;
            r_nom_interval <= pim_pkg::RST_NOM_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pim_pkg::CFG_MIN_INTERVAL: begin
                    r_min_interval <= i_cfg_data;
                end
                pim_pkg::CFG_MAX_INTERVAL: begin
                    r_max_interval <= i_cfg_data;
                end
                pim_pkg::CFG_NOM_INTERVAL: begin
                    r_nom_interval <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign i_pps.ready = conv_rdy;

    // Tick count to microseconds.
    pim_time_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_pps.valid),
        .o_rdy     (conv_rdy),
        .i_ticks   (i_pps.capture_count),
        .o_vld     (time_vld),
        .i_rdy     (time_rdy),
        .o_time_us (time_us)
    );

    // Period, limit check, jitter and counters; drives the result channel.
    pim_interval_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (time_vld),
        .o_rdy          (time_rdy),
        .i_time_us      (time_us),
        .i_min_interval (r_min_interval),
        .i_max_interval (r_max_interval),
        .i_nom_interval (r_nom_interval),
        .o_res          (o_res)
    );

endmodule

// ----- hw/rtl/pim_time_conv.sv -----
// Pipelined conversion of timer ticks to microseconds.
`timescale 1ns / 1ps

module pim_time_conv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  logic [63:0] i_ticks,
    output logic        o_vld,
    input  logic        i_rdy,
    output logic [63:0] o_time_us
);

    localparam int NSTG = 6;
    localparam int PW   = 32 + pim_pkg::US_W;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    logic [63:0]     r_ticks;
    logic [PW-1:0]   r_prod_lo;
    logic [31:0]     r_prod_hi;
    logic [63:0]     r_p;
    logic [63:0]     r_ll;
    logic [63:0]     r_lm;
    logic [63:0]     r_hl;
    logic [63:0]     r_hh;
    logic [63:0]     r_pc;
    logic [65:0]     r_mid;
    logic [64:0]     r_hi;
    logic [63:0]     r_time;
    logic [65:0]     full_hi;

    // A stage takes new data when it is empty or its successor moves on.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_rdy;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Product bits 64 and up: the upper partial sum plus the carry out of
    // the middle column.
    assign full_hi = 66'(r_hi) + 66'(r_mid[65:32]);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_ticks <= i_ticks;
        end
        // Ticks times one million, kept modulo 2^64.
        if (en[1]) begin
            r_prod_lo <= PW'(r_ticks[31:0]) * PW'(pim_pkg::US_MULT);
            r_prod_hi <= r_ticks[63:32] * 32'(pim_pkg::US_MULT);
        end
        if (en[2]) begin
            r_p <= 64'(r_prod_lo) + {r_prod_hi, 32'd0};
        end
        // Partial products against the reciprocal.
        if (en[3]) begin
            r_ll <= 64'(r_p[31:0])  * 64'(pim_pkg::RECIP_LO[31:0]);
            r_lm <= 64'(r_p[31:0])  * 64'(pim_pkg::RECIP_LO[63:32]);
            r_hl <= 64'(r_p[63:32]) * 64'(pim_pkg::RECIP_LO[31:0]);
            r_hh <= 64'(r_p[63:32]) * 64'(pim_pkg::RECIP_LO[63:32]);
            r_pc <= r_p;
        end
        if (en[4]) begin
            r_mid <= 66'(r_lm) + 66'(r_hl) + 66'(r_ll[63:32]);
            r_hi  <= 65'(r_hh) + 65'(r_pc);
        end
        if (en[5]) begin
            r_time <= 64'(full_hi >> pim_pkg::RECIP_SHIFT);
        end
    end

    assign o_rdy     = en[0];
    assign o_vld     = r_vld[NSTG-1];
    assign o_time_us = r_time;

endmodule

// ----- hw/rtl/pim_interval_check.sv -----
// Interval measurement, limit check, jitter and edge counters.
`timescale 1ns / 1ps

module pim_interval_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  logic [63:0]         i_time_us,
    input  pim_pkg::t_cfg_val   i_min_interval,
    input  pim_pkg::t_cfg_val   i_max_interval,
    input  pim_pkg::t_cfg_val   i_nom_interval,
    pim_res_if.source           o_res
);

    logic        en_f;
    logic        en_g;
    logic        r_vld_f;
    logic        r_vld_g;
    logic [63:0] r_prev;
    logic [63:0] diff;

    logic [63:0] r_now;
    logic        r_first;
    logic        r_pvalid;
    logic [31:0] r_diff;

    logic [31:0] period;
    logic        in_lim;
    logic [31:0] jit;

    logic [63:0] r_time_o;
    logic [31:0] r_period;
    logic [31:0] r_jitter;
    logic        r_first_o;
    logic        r_ok;
    logic [31:0] r_edges;
    logic [31:0] r_good;
    logic [31:0] r_bad;

    assign en_g  = !r_vld_g || o_res.ready;
    assign en_f  = !r_vld_f || en_g;
    assign o_rdy = en_f;

    assign diff = i_time_us - r_prev;

    // Stage one: difference against the stored time, which is replaced by
    // every new edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= 1'b0;
            r_prev  <= '0;
        end else begin
            if (en_f) begin
                r_vld_f <= i_vld;
            end
            if (en_f && i_vld) begin
                r_prev <= i_time_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_now    <= i_time_us;
            r_first  <= (r_prev == '0);
            r_pvalid <= (r_prev != '0) && (i_time_us > r_prev) && (diff[63:32] == '0);
            r_diff   <= diff[31:0];
        end
    end

    // Stage two: limit check and jitter.
    assign period = r_pvalid ? r_diff : '0;
    assign in_lim = r_pvalid && (period >= i_min_interval) && (period <= i_max_interval);
    assign jit    = (period >= i_nom_interval) ? (period - i_nom_interval)
                                               : (i_nom_interval - period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_g <= 1'b0;
            r_edges <= '0;
            r_good  <= '0;
            r_bad   <= '0;
        end else begin
            if (en_g) begin
                r_vld_g <= r_vld_f;
            end
            if (en_g && r_vld_f) begin
                r_edges <= r_edges + 32'd1;
                if (!r_first) begin
                    if (in_lim) begin
                        r_good <= r_good + 32'd1;
                    end else begin
                        r_bad <= r_bad + 32'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            r_time_o  <= r_now;
            r_period  <= period;
            r_jitter  <= in_lim ? jit : '0;
            r_first_o <= r_first;
            r_ok      <= in_lim;
        end
    end

    assign o_res.valid          = r_vld_g;
    assign o_res.edge_time_us   = r_time_o;
    assign o_res.period_out     = r_period;
    assign o_res.jitter_out     = r_jitter;
    assign o_res.first_edge     = r_first_o;
    assign o_res.interval_ok    = r_ok;
    assign o_res.edges_seen     = r_edges;
    assign o_res.good_intervals = r_good;
    assign o_res.bad_intervals  = r_bad;

`ifndef SYNTHESIS
    a_ok_not_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_g && r_ok) |-> (!r_first_o && (r_period != '0)))
        else $error("valid interval reported on a first edge or with zero period");

    a_jitter_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_g && (r_jitter != '0)) |-> r_ok)
        else $error("nonzero jitter on an interval outside the limits");

    a_first_no_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_g && r_first_o) |-> (r_period == '0))
        else $error("first edge carries a period");

    a_edge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_g && r_vld_f) |=> (r_edges == $past(r_edges) + 32'd1))
        else $error("edge counter did not advance by one");

    a_judged_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_g && r_vld_f && !r_first) |=>
            ((r_good + r_bad) == $past(r_good + r_bad) + 32'd1))
        else $error("judged interval not counted exactly once");
`endif

endmodule
